/* rtl/nlms_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// NLMS echo canceller package
// Sizes, fixed-point limits, register indexes and sequencer types.
// ----------------------------------------------------------------------------
package nlms_pkg;

  localparam int SMP_W         = 16;
  localparam int W_W           = 24;
  localparam int SQ_W          = 31;
  localparam int TAPS          = 512;
  localparam int TAP_AW        = $clog2(TAPS);
  localparam int BLOCK_LEN     = 256;
  localparam int BLK_AW        = $clog2(BLOCK_LEN);
  localparam int CNT_W         = (TAP_AW > BLK_AW) ? TAP_AW : BLK_AW;
  localparam int HIST_DEPTH    = 8192;
  localparam int HIST_AW       = $clog2(HIST_DEPTH);
  localparam int MAX_LAG_LIMIT = 2048;
  localparam int LAG_W         = 12;
  localparam int PWR_W         = 40;
  localparam int ACC_W         = 50;
  localparam int DEN_W         = 41;
  localparam int MAG_W         = 53;
  localparam int DIV_CW        = $clog2(MAG_W + 1);
  localparam int STEP_W        = 48;
  localparam int HOLD_W        = 7;
  localparam int CFG_AW        = 3;
  localparam int CFG_DW        = 32;

  localparam logic [HOLD_W-1:0] DTD_HOLD_LOAD = HOLD_W'(100);
  localparam logic [PWR_W-1:0]  PWR_MAX       = {PWR_W{1'b1}};
  localparam logic [MAG_W-1:0]  STEP_LIMIT    = MAG_W'((64'd1 << 47) - 64'd1);
  localparam logic signed [63:0] W_MAX        = 64'sd8388607;
  localparam logic signed [63:0] W_MIN        = -64'sd8388608;

  typedef enum logic [CFG_AW-1:0] {
    REG_STEP_SIZE       = 3'd0,
    REG_DTD_RATIO       = 3'd1,
    REG_REGULARIZATION  = 3'd2,
    REG_REF_POWER_FLOOR = 3'd3,
    REG_MAX_LAG         = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_CORR,
    MODE_FIR,
    MODE_UPD
  } run_mode_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CAPTURE,
    ST_SRCH_INIT,
    ST_RUN,
    ST_DRAIN,
    ST_LAG_CMP,
    ST_TAP_RD,
    ST_TAP_WR,
    ST_TAP_PWR,
    ST_ERR,
    ST_NUM,
    ST_DIV_LOAD,
    ST_DIV,
    ST_STEP,
    ST_ENERGY,
    ST_DTD_MUL,
    ST_DTD_CMP,
    ST_DONE
  } state_e;

endpackage
`default_nettype wire

/* rtl/nlms_echo_canceller.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// NLMS echo canceller
// Bulk-delay search, NLMS filter and double-talk hold over on-chip memories.
// ----------------------------------------------------------------------------
// Per sample: a 512-term filter walk and, unless the double-talk hold is
//   active or the denominator is zero, a bit-serial divider and a 512-term
//   weight walk; the last sample of each 256-sample block may add a lag
//   search (up to 512 coarse lags of 64 terms, up to 9 fine lags of 256
//   terms), all set by the single multiply-accumulate stream and one read
//   port per memory. One sample in flight at a time. Reset: a clearing pass
//   zeroes history, tap and weight memories; no sample is taken until it ends.
module nlms_echo_canceller
  import nlms_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_AW-1:0]        cfg_idx_i,
  input  wire logic [CFG_DW-1:0]        cfg_wdata_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic signed [SMP_W-1:0]  mic_sample_i,
  input  wire logic signed [SMP_W-1:0]  ref_sample_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic signed [SMP_W-1:0]       err_sample_o,
  output logic                          dtd_active_o,
  output logic [LAG_W-1:0]              lag_now_o
);

  // configuration
  logic [15:0]        step_size_q;
  logic [15:0]        dtd_ratio_q;
  logic [31:0]        reg_q;
  logic [31:0]        floor_q;
  logic [LAG_W-1:0]   max_lag_q;

  state_e state_q, state_d;
  run_mode_e mode_q;

  logic [HIST_AW-1:0] clr_q;
  logic [HIST_AW-1:0] hptr_q;
  logic [TAP_AW-1:0]  tptr_q;
  logic [BLK_AW-1:0]  bpos_q;
  logic [PWR_W-1:0]   brp_q;
  logic [PWR_W-1:0]   tpow_q;
  logic [PWR_W-1:0]   me_q;
  logic [PWR_W-1:0]   re_q;
  logic [HOLD_W-1:0]  hold_q;
  logic [LAG_W-1:0]   lag_reg_q;

  logic signed [SMP_W-1:0] mic_q, ref_q, err_q;
  logic [SQ_W-1:0]    mic_sq_q, ref_sq_q, r_sq_q, old_sq_q;

  // search
  logic [LAG_W-1:0]   lim_q, lag_q, best_q;
  logic [LAG_W:0]     hi_q;
  logic [ACC_W-1:0]   top_q;
  logic               coarse_q;

  // stream
  logic [CNT_W-1:0]   cnt_q;
  logic               v1_q, v2_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [39:0] prod_q;
  logic signed [39:0] ph_q;
  logic signed [40:0] pl_q;
  logic signed [W_W-1:0] w2_q;
  logic [TAP_AW-1:0]  waddr1_q, waddr2_q;

  // update
  logic signed [32:0] num_q;
  logic [DEN_W-1:0]   den_q;
  logic [DEN_W-1:0]   rem_q;
  logic [MAG_W-1:0]   dvd_q;
  logic [DIV_CW-1:0]  dcnt_q;
  logic               neg_q;
  logic signed [STEP_W-1:0] step_q;
  logic [35:0]        dtd_lo_q, dtd_hi_q;

  logic               out_valid_q;
  logic signed [SMP_W-1:0] out_err_q;
  logic               out_dtd_q;
  logic [LAG_W-1:0]   out_lag_q;

  // memories
  logic signed [SMP_W-1:0] hist_mem [HIST_DEPTH];
  logic signed [SMP_W-1:0] tap_mem  [TAPS];
  logic signed [W_W-1:0]   w_mem    [TAPS];
  logic signed [SMP_W-1:0] mic_mem  [BLOCK_LEN];
  logic signed [SMP_W-1:0] hist_rdata_q, tap_rdata_q, mic_rdata_q;
  logic signed [W_W-1:0]   w_rdata_q;

  logic                hist_we, tap_we, w_we;
  logic [HIST_AW-1:0]  hist_waddr, hist_raddr;
  logic [TAP_AW-1:0]   tap_waddr, tap_raddr, w_waddr, w_raddr;
  logic signed [SMP_W-1:0] hist_wdata, tap_wdata;
  logic signed [W_W-1:0]   w_wdata;

  // ---------------------------------------------------------------- control
  logic in_fire, run_last, drained, load_out;
  logic [LAG_W-1:0] lim_c;
  logic [ACC_W-1:0] corr_mag;
  logic             better;
  logic [LAG_W-1:0] best_n;
  logic [LAG_W:0]   coarse_nxt, fine_lo, fine_hi, best_p4;
  logic [PWR_W:0]   brp_sum;
  logic [PWR_W-1:0] brp_new;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign drained    = !v1_q && !v2_q;
  assign load_out   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  assign lim_c = (max_lag_q > LAG_W'(MAX_LAG_LIMIT)) ? LAG_W'(MAX_LAG_LIMIT) : max_lag_q;

  always_comb begin
    if (mode_q == MODE_CORR) begin
      run_last = coarse_q ? (cnt_q[BLK_AW-1:0] == BLK_AW'(BLOCK_LEN - 4))
                          : (cnt_q[BLK_AW-1:0] == BLK_AW'(BLOCK_LEN - 1));
    end else begin
      run_last = (cnt_q[TAP_AW-1:0] == TAP_AW'(TAPS - 1));
    end
  end

  assign corr_mag   = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
  assign better     = corr_mag > top_q;
  assign best_n     = better ? lag_q : best_q;
  assign coarse_nxt = {1'b0, lag_q} + (LAG_W+1)'(4);
  assign fine_lo    = (best_n >= LAG_W'(4)) ? {1'b0, best_n} - (LAG_W+1)'(4) : '0;
  assign best_p4    = {1'b0, best_n} + (LAG_W+1)'(4);
  assign fine_hi    = (best_p4 > {1'b0, lim_q}) ? {1'b0, lim_q} : best_p4;

  assign brp_sum = {1'b0, brp_q} + (PWR_W+1)'(ref_sq_q);
  assign brp_new = brp_sum[PWR_W] ? PWR_MAX : brp_sum[PWR_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:     if (clr_q == HIST_AW'(HIST_DEPTH - 1)) state_d = ST_IDLE;
      ST_IDLE:      if (in_fire) state_d = ST_CAPTURE;
      ST_CAPTURE: begin
        if (bpos_q == BLK_AW'(BLOCK_LEN - 1) && hold_q == '0 &&
            brp_new > PWR_W'(floor_q)) begin
          state_d = ST_SRCH_INIT;
        end else begin
          state_d = ST_TAP_RD;
        end
      end
      ST_SRCH_INIT: state_d = (lim_c == '0) ? ST_TAP_RD : ST_RUN;
      ST_RUN:       if (run_last) state_d = ST_DRAIN;
      ST_DRAIN: begin
        if (drained) begin
          unique case (mode_q)
            MODE_CORR: state_d = ST_LAG_CMP;
            MODE_FIR:  state_d = ST_ERR;
            default:   state_d = ST_ENERGY;
          endcase
        end
      end
      ST_LAG_CMP: begin
        if (coarse_q) begin
          if (coarse_nxt < {1'b0, lim_q}) begin
            state_d = ST_RUN;
          end else if (fine_lo > fine_hi) begin
            state_d = ST_TAP_RD;
          end else begin
            state_d = ST_RUN;
          end
        end else begin
          state_d = ({1'b0, lag_q} < hi_q) ? ST_RUN : ST_TAP_RD;
        end
      end
      ST_TAP_RD:    state_d = ST_TAP_WR;
      ST_TAP_WR:    state_d = ST_TAP_PWR;
      ST_TAP_PWR:   state_d = ST_RUN;
      ST_ERR:       state_d = ST_NUM;
      ST_NUM:       state_d = ST_DIV_LOAD;
      ST_DIV_LOAD:  state_d = (hold_q == '0 && den_q != '0) ? ST_DIV : ST_ENERGY;
      ST_DIV:       if (dcnt_q == DIV_CW'(MAG_W - 1)) state_d = ST_STEP;
      ST_STEP:      state_d = ST_RUN;
      ST_ENERGY:    state_d = ST_DTD_MUL;
      ST_DTD_MUL:   state_d = ST_DTD_CMP;
      ST_DTD_CMP:   state_d = ST_DONE;
      ST_DONE:      if (load_out) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------- configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_size_q <= 16'd3277;
      dtd_ratio_q <= 16'd8192;
      reg_q       <= 32'd1;
      floor_q     <= 32'd1;
      max_lag_q   <= LAG_W'(MAX_LAG_LIMIT);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_STEP_SIZE:       step_size_q <= cfg_wdata_i[15:0];
        REG_DTD_RATIO:       dtd_ratio_q <= cfg_wdata_i[15:0];
        REG_REGULARIZATION:  reg_q       <= cfg_wdata_i;
        REG_REF_POWER_FLOOR: floor_q     <= cfg_wdata_i;
        REG_MAX_LAG:         max_lag_q   <= cfg_wdata_i[LAG_W-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------- memory addressing
  always_comb begin
    hist_we    = (state_q == ST_CLEAR) || (state_q == ST_CAPTURE);
    hist_waddr = (state_q == ST_CLEAR) ? clr_q : hptr_q;
    hist_wdata = (state_q == ST_CLEAR) ? '0 : ref_q;
    if (state_q == ST_TAP_RD) begin
      hist_raddr = hptr_q - HIST_AW'(1) - HIST_AW'(lag_reg_q);
    end else begin
      hist_raddr = hptr_q - HIST_AW'(BLOCK_LEN) - HIST_AW'(lag_q)
                 + HIST_AW'(cnt_q[BLK_AW-1:0]);
    end

    tap_we    = (state_q == ST_CLEAR) || (state_q == ST_TAP_WR);
    tap_waddr = (state_q == ST_CLEAR) ? clr_q[TAP_AW-1:0] : tptr_q;
    tap_wdata = (state_q == ST_CLEAR) ? '0 : hist_rdata_q;
    tap_raddr = (state_q == ST_TAP_RD) ? tptr_q : tptr_q - cnt_q[TAP_AW-1:0];

    w_we    = (state_q == ST_CLEAR) || (v2_q && mode_q == MODE_UPD);
    w_waddr = (state_q == ST_CLEAR) ? clr_q[TAP_AW-1:0] : waddr2_q;
    w_raddr = cnt_q[TAP_AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
    hist_rdata_q <= hist_mem[hist_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (tap_we) tap_mem[tap_waddr] <= tap_wdata;
    tap_rdata_q <= tap_mem[tap_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (w_we) w_mem[w_waddr] <= w_wdata;
    w_rdata_q <= w_mem[w_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CAPTURE) mic_mem[bpos_q] <= mic_q;
    mic_rdata_q <= mic_mem[cnt_q[BLK_AW-1:0]];
  end

  // ------------------------------------------------- stream datapath stages
  logic signed [W_W-1:0]   opa;
  logic signed [SMP_W-1:0] opb;
  logic signed [63:0]      upd_p, upd_w;

  assign opa = (mode_q == MODE_CORR) ? W_W'(mic_rdata_q) : w_rdata_q;
  assign opb = (mode_q == MODE_CORR) ? hist_rdata_q : tap_rdata_q;

  always_comb begin
    upd_p = (64'(ph_q) <<< 24) + 64'(pl_q);
    upd_w = 64'(w2_q) + ((upd_p + 64'sd16384) >>> 15);
    if (state_q == ST_CLEAR) begin
      w_wdata = '0;
    end else if (upd_w > W_MAX) begin
      w_wdata = W_W'(W_MAX);
    end else if (upd_w < W_MIN) begin
      w_wdata = W_W'(W_MIN);
    end else begin
      w_wdata = upd_w[W_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= opa * opb;
    ph_q     <= $signed(step_q[STEP_W-1:24]) * tap_rdata_q;
    pl_q     <= $signed({1'b0, step_q[23:0]}) * tap_rdata_q;
    w2_q     <= w_rdata_q;
    waddr1_q <= cnt_q[TAP_AW-1:0];
    waddr2_q <= waddr1_q;
  end

  // ------------------------------------------------------- arithmetic steps
  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [29:0]      ev;
  logic signed [41:0]      tp_new;
  logic [DEN_W:0]          div_t;
  logic                    div_ge;
  logic [31:0]             num_abs;
  logic [STEP_W-2:0]       q_clamp;
  logic [55:0]             dtd_rhs;
  logic [55:0]             dtd_lhs;

  assign acc_rnd = acc_q + ACC_W'(64'sd2097152);
  assign ev      = 30'(mic_q) - 30'($signed(acc_rnd[ACC_W-1:22]));
  assign tp_new  = $signed({2'b00, tpow_q}) - $signed(42'(old_sq_q))
                 + $signed(42'(r_sq_q));
  assign div_t   = {rem_q, dvd_q[MAG_W-1]};
  assign div_ge  = div_t >= {1'b0, den_q};
  assign num_abs = num_q[32] ? 32'(-num_q) : num_q[31:0];
  assign q_clamp = (dvd_q > STEP_LIMIT) ? STEP_LIMIT[STEP_W-2:0] : dvd_q[STEP_W-2:0];
  assign dtd_rhs = {dtd_hi_q, 20'd0} + 56'(dtd_lo_q);
  assign dtd_lhs = {4'd0, me_q, 12'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_CORR;
      clr_q       <= '0;
      hptr_q      <= '0;
      tptr_q      <= '0;
      bpos_q      <= '0;
      brp_q       <= '0;
      tpow_q      <= '0;
      me_q        <= '0;
      re_q        <= '0;
      hold_q      <= '0;
      lag_reg_q   <= '0;
      coarse_q    <= 1'b0;
      cnt_q       <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      v1_q <= (state_q == ST_RUN);
      v2_q <= v1_q;
      if (state_q == ST_CLEAR) clr_q <= clr_q + HIST_AW'(1);

      // start of each stream run
      if (state_q != ST_RUN && state_d == ST_RUN) begin
        cnt_q <= '0;
      end else if (state_q == ST_RUN) begin
        cnt_q <= cnt_q + ((mode_q == MODE_CORR && coarse_q) ? CNT_W'(4) : CNT_W'(1));
      end

      unique case (state_q)
        ST_CAPTURE: begin
          hptr_q <= hptr_q + HIST_AW'(1);
          if (bpos_q == BLK_AW'(BLOCK_LEN - 1)) begin
            bpos_q <= '0;
            brp_q  <= '0;
          end else begin
            bpos_q <= bpos_q + BLK_AW'(1);
            brp_q  <= brp_new;
          end
        end
        ST_SRCH_INIT: begin
          mode_q   <= MODE_CORR;
          coarse_q <= 1'b1;
        end
        ST_LAG_CMP: begin
          if (coarse_q) begin
            if (coarse_nxt >= {1'b0, lim_q}) begin
              coarse_q <= 1'b0;
              if (fine_lo > fine_hi) lag_reg_q <= best_n;
            end
          end else if ({1'b0, lag_q} >= hi_q) begin
            lag_reg_q <= best_n;
          end
        end
        ST_TAP_PWR: begin
          mode_q <= MODE_FIR;
          if (tp_new < 0) begin
            tpow_q <= '0;
          end else if (tp_new > $signed({2'b00, PWR_MAX})) begin
            tpow_q <= PWR_MAX;
          end else begin
            tpow_q <= tp_new[PWR_W-1:0];
          end
        end
        ST_DIV_LOAD: dcnt_q <= '0;
        ST_DIV:      dcnt_q <= dcnt_q + DIV_CW'(1);
        ST_STEP:     mode_q <= MODE_UPD;
        ST_ENERGY: begin
          me_q <= me_q - (me_q >> 10) + PWR_W'(mic_sq_q >> 10);
          re_q <= re_q - (re_q >> 10) + PWR_W'(r_sq_q >> 10);
        end
        ST_DTD_CMP: begin
          tptr_q <= tptr_q + TAP_AW'(1);
          if (dtd_lhs > dtd_rhs && re_q > PWR_W'(floor_q)) begin
            hold_q <= DTD_HOLD_LOAD;
          end else if (hold_q != '0) begin
            hold_q <= hold_q - HOLD_W'(1);
          end
        end
        default: ;
      endcase

      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mic_q    <= mic_sample_i;
      ref_q    <= ref_sample_i;
      mic_sq_q <= SQ_W'(mic_sample_i * mic_sample_i);
      ref_sq_q <= SQ_W'(ref_sample_i * ref_sample_i);
    end

    if (state_q != ST_RUN && state_d == ST_RUN) begin
      acc_q <= '0;
    end else if (v2_q && mode_q != MODE_UPD) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end

    unique case (state_q)
      ST_SRCH_INIT: begin
        lim_q  <= lim_c;
        lag_q  <= '0;
        best_q <= lag_reg_q;
        top_q  <= '0;
      end
      ST_LAG_CMP: begin
        best_q <= best_n;
        if (coarse_q && coarse_nxt >= {1'b0, lim_q}) begin
          // coarse pass over: refine around the best lag
          top_q <= '0;
          lag_q <= fine_lo[LAG_W-1:0];
          hi_q  <= fine_hi;
        end else begin
          top_q <= better ? corr_mag : top_q;
          lag_q <= coarse_q ? coarse_nxt[LAG_W-1:0] : lag_q + LAG_W'(1);
        end
      end
      ST_TAP_WR: begin
        r_sq_q   <= SQ_W'(hist_rdata_q * hist_rdata_q);
        old_sq_q <= SQ_W'(tap_rdata_q * tap_rdata_q);
      end
      ST_ERR: begin
        if (ev > 30'sd32767) begin
          err_q <= 16'sh7FFF;
        end else if (ev < -30'sd32768) begin
          err_q <= -16'sh8000;
        end else begin
          err_q <= ev[SMP_W-1:0];
        end
      end
      ST_NUM: begin
        num_q <= $signed({1'b0, step_size_q}) * err_q;
        den_q <= DEN_W'(tpow_q) + DEN_W'(reg_q);
      end
      ST_DIV_LOAD: begin
        rem_q <= '0;
        dvd_q <= {num_abs, 21'd0};
        neg_q <= num_q[32];
      end
      ST_DIV: begin
        rem_q <= div_ge ? DEN_W'(div_t - {1'b0, den_q}) : div_t[DEN_W-1:0];
        dvd_q <= {dvd_q[MAG_W-2:0], div_ge};
      end
      ST_STEP: begin
        step_q <= neg_q ? -$signed({1'b0, q_clamp}) : $signed({1'b0, q_clamp});
      end
      ST_DTD_MUL: begin
        dtd_lo_q <= dtd_ratio_q * re_q[19:0];
        dtd_hi_q <= dtd_ratio_q * re_q[PWR_W-1:20];
      end
      default: ;
    endcase

    if (load_out) begin
      out_err_q <= err_q;
      out_dtd_q <= (hold_q != '0);
      out_lag_q <= lag_reg_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign err_sample_o = out_err_q;
  assign dtd_active_o = out_dtd_q;
  assign lag_now_o    = out_lag_q;

  // ------------------------------------------------------------- assertions
  a_upd_no_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && mode_q == MODE_UPD) |-> (hold_q == '0))
    else $error("weight update while double-talk hold active");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < den_q))
    else $error("divider remainder out of range");

  a_lag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lag_reg_q <= LAG_W'(MAX_LAG_LIMIT))
    else $error("bulk lag beyond limit");

  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !out_valid_q) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("finished sample not moved to output register");

endmodule
`default_nettype wire
